// ----- design/fth_pkg.sv -----
package fth_pkg;

  localparam int HERTZ_W = 39;
  localparam int FRAC_W = 30;
  localparam int COUNT_W = 4;
  localparam int EXP_W = 4;
  localparam int UNIT_KEEP = 3;

  localparam int FRACTION_DIGITS_DEF = 9;
  localparam int UNIT_CHARS_DEF = 7;

  localparam logic [HERTZ_W-1:0] HZ_LIMIT = 39'd300000000000;

  localparam logic [31:0] RECIP_10 = 32'hCCCCCCCD;
  localparam int RECIP_SHIFT = 35;

  localparam logic [7:0] CH_NUL = 8'h00;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_DOT = 8'h2E;
  localparam logic [7:0] CH_0 = 8'h30;
  localparam logic [7:0] CH_9 = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UZ = 8'h5A;
  localparam logic [7:0] CH_CASE = 8'h20;
  localparam logic [7:0] CH_G = 8'h67;
  localparam logic [7:0] CH_H = 8'h68;
  localparam logic [7:0] CH_K = 8'h6B;
  localparam logic [7:0] CH_M = 8'h6D;
  localparam logic [7:0] CH_Z = 8'h7A;

  typedef struct packed {
    logic take;
    logic decode;
    logic step;
    logic finish;
  } fth_cmd_t;

  typedef struct packed {
    logic scale_done;
  } fth_status_t;

endpackage

// ----- design/fth_ctrl.sv -----
module fth_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 text_valid,
  input  logic                 last_byte,
  output logic                 text_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  fth_pkg::fth_status_t st,
  output fth_pkg::fth_cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_BYTES,
    S_DECODE,
    S_SCALE
  } ctrl_state_t;

  ctrl_state_t state;
  logic        out_free;

  always_comb begin
    text_ready = (state == S_BYTES);
    out_free = !result_valid || result_ready;
    cmd.take = text_valid && text_ready;
    cmd.decode = (state == S_DECODE);
    cmd.step = (state == S_SCALE) && !st.scale_done;
    cmd.finish = (state == S_SCALE) && st.scale_done && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_BYTES;
      result_valid <= 1'b0;
    end else begin
      case (state)
        S_BYTES: begin
          if (cmd.take && last_byte) state <= S_DECODE;
        end
        S_DECODE: begin
          state <= S_SCALE;
        end
        S_SCALE: begin
          if (cmd.finish) state <= S_BYTES;
        end
        default: begin
          state <= S_BYTES;
        end
      endcase
      if (cmd.finish) result_valid <= 1'b1;
      else if (result_ready) result_valid <= 1'b0;
    end
  end

  a_finish_loads: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCALE && st.scale_done && (!result_valid || result_ready)) |=> result_valid)
    else $error("result not loaded after scaling");

  a_last_decodes: assert property (@(posedge clk) disable iff (rst)
    (text_valid && text_ready && last_byte) |=> (state == S_DECODE))
    else $error("final item did not start decode");

  a_decode_scales: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECODE) |=> (state == S_SCALE))
    else $error("decode not followed by scaling");

endmodule

// ----- design/fth_datapath.sv -----
module fth_datapath #(
  parameter int FRACTION_DIGITS = fth_pkg::FRACTION_DIGITS_DEF,
  parameter int UNIT_CHARS = fth_pkg::UNIT_CHARS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  fth_pkg::fth_cmd_t            cmd,
  output fth_pkg::fth_status_t         st,
  input  logic [7:0]                   text_byte,
  output logic                         parse_ok,
  output logic [fth_pkg::HERTZ_W-1:0]  hertz
);

  localparam int ULEN_W = $clog2(UNIT_CHARS + 1);
  localparam int WIDE_W = fth_pkg::HERTZ_W + 4;
  localparam int PROD_W = fth_pkg::FRAC_W + 32;

  typedef enum logic [2:0] {
    PH_LEAD,
    PH_WHOLE,
    PH_FRAC,
    PH_GAP,
    PH_UNIT,
    PH_DONE
  } phase_t;

  phase_t                             parse_phase, parse_phase_next;
  logic [fth_pkg::HERTZ_W-1:0]        whole_value, whole_value_next;
  logic                               whole_overflow, whole_overflow_next;
  logic [fth_pkg::FRAC_W-1:0]         fraction_value, fraction_value_next;
  logic [fth_pkg::COUNT_W-1:0]        fraction_count, fraction_count_next;
  logic                               seen_digit, seen_digit_next;
  logic [ULEN_W-1:0]                  unit_length, unit_length_next;
  logic                               text_ended, text_ended_next;
  logic [7:0]                         unit_store [fth_pkg::UNIT_KEEP];
  logic                               unit_we;
  logic                               result_bad, result_bad_next;
  logic [fth_pkg::EXP_W-1:0]          whole_steps, whole_steps_next;
  logic signed [4:0]                  frac_shift, frac_shift_next;

  logic                               is_digit, is_point, is_blank, unit_add;
  logic [3:0]                         digit;
  logic [7:0]                         folded;
  logic [WIDE_W-1:0]                  whole_x10, whole_cand;
  logic [fth_pkg::FRAC_W-1:0]         frac_x10, frac_div10;
  logic [PROD_W-1:0]                  div_prod;
  logic                               unit_known;
  logic [fth_pkg::EXP_W-1:0]          unit_exp;
  logic [fth_pkg::HERTZ_W-1:0]        sum;
  logic                               sum_ok;

  function automatic logic [fth_pkg::HERTZ_W-1:0] whole_limit(
    input logic [fth_pkg::EXP_W-1:0] e
  );
    logic [fth_pkg::HERTZ_W-1:0] lim;
    case (e)
      4'd3:    lim = 39'd300000000;
      4'd6:    lim = 39'd300000;
      4'd9:    lim = 39'd300;
      default: lim = fth_pkg::HZ_LIMIT;
    endcase
    return lim;
  endfunction

  always_comb begin
    is_digit = (text_byte >= fth_pkg::CH_0) && (text_byte <= fth_pkg::CH_9);
    is_point = (text_byte == fth_pkg::CH_DOT) || (text_byte == fth_pkg::CH_COMMA);
    is_blank = (text_byte == fth_pkg::CH_SPACE) || (text_byte == fth_pkg::CH_TAB);
    digit = 4'(text_byte - fth_pkg::CH_0);
    folded = ((text_byte >= fth_pkg::CH_UA) && (text_byte <= fth_pkg::CH_UZ)) ?
             (text_byte + fth_pkg::CH_CASE) : text_byte;
    whole_x10 = (WIDE_W'(whole_value) << 3) + (WIDE_W'(whole_value) << 1);
    whole_cand = whole_x10 + WIDE_W'(digit);
    frac_x10 = (fraction_value << 3) + (fraction_value << 1);
    div_prod = PROD_W'(fraction_value) * PROD_W'(fth_pkg::RECIP_10);
    frac_div10 = fth_pkg::FRAC_W'(div_prod >> fth_pkg::RECIP_SHIFT);

    unit_known = 1'b0;
    unit_exp = 4'd6;
    case (unit_length)
      ULEN_W'(0): begin
        unit_known = 1'b1;
      end
      ULEN_W'(1): begin
        unit_known = (unit_store[0] == fth_pkg::CH_K) || (unit_store[0] == fth_pkg::CH_M) ||
                     (unit_store[0] == fth_pkg::CH_G);
      end
      ULEN_W'(2): begin
        unit_known = (unit_store[0] == fth_pkg::CH_H) && (unit_store[1] == fth_pkg::CH_Z);
        unit_exp = 4'd0;
      end
      ULEN_W'(3): begin
        unit_known = (unit_store[1] == fth_pkg::CH_H) && (unit_store[2] == fth_pkg::CH_Z) &&
                     ((unit_store[0] == fth_pkg::CH_K) || (unit_store[0] == fth_pkg::CH_M) ||
                      (unit_store[0] == fth_pkg::CH_G));
      end
      default: begin
        unit_known = 1'b0;
      end
    endcase
    if (unit_length == ULEN_W'(1) || unit_length == ULEN_W'(3)) begin
      if (unit_store[0] == fth_pkg::CH_K) unit_exp = 4'd3;
      else if (unit_store[0] == fth_pkg::CH_G) unit_exp = 4'd9;
      else unit_exp = 4'd6;
    end

    sum = whole_value + fth_pkg::HERTZ_W'(fraction_value);
    sum_ok = !result_bad && (sum != '0) && (sum <= fth_pkg::HZ_LIMIT);
    st.scale_done = (whole_steps == '0) && (frac_shift == 5'sd0);

    parse_phase_next = parse_phase;
    whole_value_next = whole_value;
    whole_overflow_next = whole_overflow;
    fraction_value_next = fraction_value;
    fraction_count_next = fraction_count;
    seen_digit_next = seen_digit;
    unit_length_next = unit_length;
    text_ended_next = text_ended;
    result_bad_next = result_bad;
    whole_steps_next = whole_steps;
    frac_shift_next = frac_shift;
    unit_add = 1'b0;
    unit_we = 1'b0;

    if (cmd.take && !text_ended) begin
      if (text_byte == fth_pkg::CH_NUL) begin
        text_ended_next = 1'b1;
      end else begin
        case (parse_phase)
          PH_LEAD, PH_WHOLE: begin
            if (is_digit) begin
              if (!whole_overflow) begin
                if (whole_cand > WIDE_W'(fth_pkg::HZ_LIMIT)) whole_overflow_next = 1'b1;
                else whole_value_next = whole_cand[fth_pkg::HERTZ_W-1:0];
              end
              seen_digit_next = 1'b1;
              parse_phase_next = PH_WHOLE;
            end else if (is_point) begin
              parse_phase_next = PH_FRAC;
            end else if (is_blank) begin
              if (parse_phase == PH_WHOLE) parse_phase_next = PH_GAP;
            end else begin
              unit_add = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_digit) begin
              if (fraction_count < fth_pkg::COUNT_W'(FRACTION_DIGITS)) begin
                fraction_value_next = frac_x10 + fth_pkg::FRAC_W'(digit);
                fraction_count_next = fraction_count + 1'b1;
              end
              seen_digit_next = 1'b1;
            end else if (is_blank) begin
              parse_phase_next = PH_GAP;
            end else begin
              unit_add = 1'b1;
            end
          end
          PH_GAP: begin
            if (!is_blank) unit_add = 1'b1;
          end
          PH_UNIT: begin
            if (text_byte == fth_pkg::CH_SPACE) parse_phase_next = PH_DONE;
            else unit_add = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    if (unit_add) begin
      parse_phase_next = PH_UNIT;
      if (unit_length < ULEN_W'(UNIT_CHARS)) begin
        unit_length_next = unit_length + 1'b1;
        unit_we = (unit_length < ULEN_W'(fth_pkg::UNIT_KEEP));
      end
    end

    if (cmd.decode) begin
      result_bad_next = !seen_digit || whole_overflow || !unit_known ||
                        (whole_value > whole_limit(unit_exp));
      whole_steps_next = unit_exp;
      frac_shift_next = $signed({1'b0, unit_exp} - {1'b0, fraction_count});
    end

    if (cmd.step) begin
      if (whole_steps != '0) begin
        whole_value_next = whole_x10[fth_pkg::HERTZ_W-1:0];
        whole_steps_next = whole_steps - 1'b1;
      end
      if (frac_shift > 5'sd0) begin
        fraction_value_next = frac_x10;
        frac_shift_next = frac_shift - 5'sd1;
      end else if (frac_shift < 5'sd0) begin
        fraction_value_next = frac_div10;
        frac_shift_next = frac_shift + 5'sd1;
      end
    end

    if (cmd.finish) begin
      parse_phase_next = PH_LEAD;
      whole_value_next = '0;
      whole_overflow_next = 1'b0;
      fraction_value_next = '0;
      fraction_count_next = '0;
      seen_digit_next = 1'b0;
      unit_length_next = '0;
      text_ended_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      parse_phase <= PH_LEAD;
      whole_value <= '0;
      whole_overflow <= 1'b0;
      fraction_value <= '0;
      fraction_count <= '0;
      seen_digit <= 1'b0;
      unit_length <= '0;
      text_ended <= 1'b0;
      result_bad <= 1'b0;
      whole_steps <= '0;
      frac_shift <= 5'sd0;
    end else begin
      parse_phase <= parse_phase_next;
      whole_value <= whole_value_next;
      whole_overflow <= whole_overflow_next;
      fraction_value <= fraction_value_next;
      fraction_count <= fraction_count_next;
      seen_digit <= seen_digit_next;
      unit_length <= unit_length_next;
      text_ended <= text_ended_next;
      result_bad <= result_bad_next;
      whole_steps <= whole_steps_next;
      frac_shift <= frac_shift_next;
    end
  end

  always_ff @(posedge clk) begin
    if (unit_we) unit_store[unit_length[1:0]] <= folded;
    if (cmd.finish) begin
      parse_ok <= sum_ok;
      hertz <= sum_ok ? sum : '0;
    end
  end

  a_frac_count_cap: assert property (@(posedge clk) disable iff (rst)
    fraction_count <= fth_pkg::COUNT_W'(FRACTION_DIGITS))
    else $error("fraction digit count beyond limit");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> (whole_value == '0 && fraction_count == '0 && !seen_digit &&
                    unit_length == '0 && parse_phase == PH_LEAD))
    else $error("parse state not cleared after result");

  a_no_take_in_scale: assert property (@(posedge clk) disable iff (rst)
    (whole_steps != '0 || frac_shift != 5'sd0) |-> !cmd.take)
    else $error("item taken while scaling");

endmodule

// ----- design/frequency_text_to_hertz_core.sv -----
// Frequency text parser: takes a string one byte per item (last_byte marks the
// final one) and returns one result per string, parse_ok and whole hertz.
// Bytes are accepted only while a string is collected. After the final byte the
// block decodes the unit word, then scales the whole part by E decades and the
// fraction by E - F, with E the unit's power of ten (0, 3, 6 or 9) and F the
// number of kept fraction digits, multiplying or dividing by ten once a cycle.
// A result is loaded once scaling is done and the result register is free; the
// next string's first byte is accepted in the cycle after that. The result
// register holds one finished result while the next string streams in.
module frequency_text_to_hertz_core #(
  parameter int FRACTION_DIGITS = fth_pkg::FRACTION_DIGITS_DEF,
  parameter int UNIT_CHARS = fth_pkg::UNIT_CHARS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        text_valid,
  output logic                        text_ready,
  input  logic [7:0]                  text_byte,
  input  logic                        last_byte,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic                        parse_ok,
  output logic [fth_pkg::HERTZ_W-1:0] hertz
);

  fth_pkg::fth_cmd_t    cmd;
  fth_pkg::fth_status_t st;

  fth_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .last_byte    (last_byte),
    .text_ready   (text_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .st           (st),
    .cmd          (cmd)
  );

  fth_datapath #(
    .FRACTION_DIGITS (FRACTION_DIGITS),
    .UNIT_CHARS      (UNIT_CHARS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .st        (st),
    .text_byte (text_byte),
    .parse_ok  (parse_ok),
    .hertz     (hertz)
  );

endmodule
